// ===== rtl/core/tds_pkg.sv =====
`timescale 1ns / 1ps

package tds_pkg;

  // Field widths of one word on each channel
  localparam int TASK_ID_W = 4;
  localparam int PRIO_W    = 7;
  localparam int TIME_W    = 8;
  localparam int ARR_W     = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = 8'd10;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_SLICE  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_LOADED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEAR  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b1;

  typedef enum logic [1:0] {
    POL_ARRIVAL = 2'd0,
    POL_BURST   = 2'd1,
    POL_PRIO    = 2'd2,
    POL_RR      = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DISPATCH,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [TASK_ID_W-1:0] id;
    logic [PRIO_W-1:0]    prio;
    logic [TIME_W-1:0]    rem;
    logic [ARR_W-1:0]     arr;
  } task_t;

  typedef struct packed {
    op_t   op;
    task_t tsk;
  } cmd_t;

  // Sort key of a task under a policy, zero extended to the widest key
  function automatic logic [ARR_W-1:0] key_of(task_t t, policy_t p);
    logic [ARR_W-1:0] k;
    case (p)
      POL_BURST: k = ARR_W'(t.rem);
      POL_PRIO:  k = ARR_W'(t.prio);
      default:   k = t.arr;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/tds_if.sv =====
`timescale 1ns / 1ps

// Task words into the scheduler
interface tds_in_if;
  logic                            valid;
  logic                            ready;
  logic [tds_pkg::KIND_W-1:0]      kind;
  logic [tds_pkg::TASK_ID_W-1:0]   task_id;
  logic [tds_pkg::PRIO_W-1:0]      priority_req;
  logic [tds_pkg::TIME_W-1:0]      burst;
  logic [tds_pkg::ARR_W-1:0]       arrival;

  modport source (output valid, kind, task_id, priority_req, burst, arrival, input ready);
  modport sink   (input valid, kind, task_id, priority_req, burst, arrival, output ready);
endinterface

// Result words out of the scheduler
interface tds_out_if;
  logic                            valid;
  logic                            ready;
  logic [tds_pkg::STATUS_W-1:0]    status;
  logic [tds_pkg::TASK_ID_W-1:0]   run_id;
  logic [tds_pkg::TIME_W-1:0]      ran;
  logic [tds_pkg::TIME_W-1:0]      remaining;
  logic                            finished;

  modport source (output valid, status, run_id, ran, remaining, finished, input ready);
  modport sink   (input valid, status, run_id, ran, remaining, finished, output ready);
endinterface

// Configuration register writes
interface tds_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tds_pkg::CFG_IDX_W-1:0]   index;
  logic [tds_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tds_front.sv =====
`timescale 1ns / 1ps

// Accepts input words, classifies them and holds one command for the queue
module tds_front (
  input  logic          clk,
  input  logic          rst,
  tds_in_if.sink        in_ch,
  output logic          cmd_valid,
  output tds_pkg::cmd_t cmd,
  input  logic          cmd_ready
);

  logic          slot_valid;
  logic          kind_ok;
  tds_pkg::op_t  op_dec;
  logic          take;

  assign in_ch.ready = !slot_valid || cmd_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = slot_valid;

  // Decode kind; the unused code is dropped without a result
  always_comb begin
    kind_ok = in_ch.kind inside {tds_pkg::KIND_LOAD, tds_pkg::KIND_DISPATCH,
                                 tds_pkg::KIND_CLEAR};
    case (in_ch.kind)
      tds_pkg::KIND_LOAD:     op_dec = tds_pkg::OP_LOAD;
      tds_pkg::KIND_DISPATCH: op_dec = tds_pkg::OP_DISPATCH;
      default:                op_dec = tds_pkg::OP_CLEAR;
    endcase
  end

  // Command slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (take) begin
      slot_valid <= kind_ok;
    end else if (cmd_ready) begin
      slot_valid <= 1'b0;
    end
    if (take) begin
      cmd.op       <= op_dec;
      cmd.tsk.id   <= in_ch.task_id;
      cmd.tsk.prio <= in_ch.priority_req;
      cmd.tsk.rem  <= in_ch.burst;
      cmd.tsk.arr  <= in_ch.arrival;
    end
  end

endmodule

// ===== rtl/core/tds_queue.sv =====
`timescale 1ns / 1ps

// Short command FIFO between the front and the back
module tds_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  tds_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output tds_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);

  localparam int PW = (tds_pkg::QUEUE_DEPTH > 1) ? $clog2(tds_pkg::QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(tds_pkg::QUEUE_DEPTH + 1);

  tds_pkg::cmd_t slots [tds_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;
  logic          push;
  logic          pop;

  assign push_ready = level != LW'(tds_pkg::QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/core/tds_back.sv =====
`timescale 1ns / 1ps

// Executes commands against the sorted task table and registers the result
module tds_back #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tds_pkg::policy_t                     policy,
  input  logic [tds_pkg::TIME_W-1:0]           quantum,
  input  logic                                 cmd_valid,
  input  tds_pkg::cmd_t                        cmd,
  output logic                                 cmd_ready,
  tds_out_if.source                            out_ch,
  output logic [$clog2(MAX_TASKS+1)-1:0]       count
);

  localparam int CW = $clog2(MAX_TASKS + 1);

  tds_pkg::task_t              tbl       [MAX_TASKS];
  tds_pkg::task_t              up_cell   [MAX_TASKS];
  tds_pkg::task_t              down_cell [MAX_TASKS];
  logic [MAX_TASKS-1:0]        hit;
  logic [MAX_TASKS-1:0]        below;
  logic [tds_pkg::ARR_W-1:0]   new_key;
  logic                        take;
  logic                        full;
  logic                        rr;
  logic [tds_pkg::TIME_W-1:0]  slice;
  logic [tds_pkg::TIME_W-1:0]  left;
  logic                        requeue;
  logic [CW-1:0]               last;
  tds_pkg::task_t              head_next;
  logic [tds_pkg::STATUS_W-1:0]  res_status;
  logic [tds_pkg::TASK_ID_W-1:0] res_run_id;
  logic [tds_pkg::TIME_W-1:0]    res_ran;
  logic [tds_pkg::TIME_W-1:0]    res_remaining;
  logic                          res_finished;

  assign cmd_ready = !out_ch.valid || out_ch.ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = count == CW'(MAX_TASKS);
  assign rr        = policy == tds_pkg::POL_RR;
  assign last      = count - 1'b1;

  // Neighbor taps for shifting the row up (insert) and down (dispatch)
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign up_cell[g] = cmd.tsk;
    end else begin : g_up
      assign up_cell[g] = tbl[g-1];
    end
    if (g == MAX_TASKS - 1) begin : g_last
      assign down_cell[g] = tbl[g];
    end else begin : g_down
      assign down_cell[g] = tbl[g+1];
    end
  end

  // Insert position: first used cell with a larger key, else the fill point
  always_comb begin
    new_key = tds_pkg::key_of(cmd.tsk, policy);
    for (int i = 0; i < MAX_TASKS; i++) begin
      hit[i] = ((CW'(i) < count) && (tds_pkg::key_of(tbl[i], policy) > new_key))
               || (CW'(i) == count);
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      below[i] = |(hit & ((MAX_TASKS'(1) << i) - MAX_TASKS'(1)));
    end
  end

  // Head slice for round robin
  always_comb begin
    slice     = (tbl[0].rem < quantum) ? tbl[0].rem : quantum;
    left      = tbl[0].rem - slice;
    requeue   = rr && (left != '0);
    head_next = tbl[0];
    head_next.rem = left;
  end

  // Result fields for the command at the queue head
  always_comb begin
    res_status    = tds_pkg::STAT_CLEAR;
    res_run_id    = '0;
    res_ran       = '0;
    res_remaining = '0;
    res_finished  = 1'b0;
    case (cmd.op)
      tds_pkg::OP_LOAD: begin
        res_status = full ? tds_pkg::STAT_FULL : tds_pkg::STAT_LOADED;
      end
      tds_pkg::OP_DISPATCH: begin
        if (count == '0) begin
          res_status = tds_pkg::STAT_EMPTY;
        end else begin
          res_status    = tds_pkg::STAT_SLICE;
          res_run_id    = tbl[0].id;
          res_ran       = rr ? slice : tbl[0].rem;
          res_remaining = rr ? left : '0;
          res_finished  = !requeue;
        end
      end
      default: res_status = tds_pkg::STAT_CLEAR;
    endcase
  end

  // Task table row
  always_ff @(posedge clk) begin
    if (take) begin
      case (cmd.op)
        tds_pkg::OP_LOAD: begin
          if (!full) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              if (hit[i] || below[i]) begin
                tbl[i] <= below[i] ? up_cell[i] : cmd.tsk;
              end
            end
          end
        end
        tds_pkg::OP_DISPATCH: begin
          if (count != '0) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              tbl[i] <= (requeue && (CW'(i) == last)) ? head_next : down_cell[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else if (take) begin
      out_ch.valid <= 1'b1;
      case (cmd.op)
        tds_pkg::OP_LOAD: begin
          if (!full) count <= count + 1'b1;
        end
        tds_pkg::OP_DISPATCH: begin
          if ((count != '0) && !requeue) count <= last;
        end
        default: count <= '0;
      endcase
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (take) begin
      out_ch.status    <= res_status;
      out_ch.run_id    <= res_run_id;
      out_ch.ran       <= res_ran;
      out_ch.remaining <= res_remaining;
      out_ch.finished  <= res_finished;
    end
  end

endmodule

// ===== rtl/core/task_dispatch_scheduler_top.sv =====
`timescale 1ns / 1ps
// An accepted input word passes the front slot, the command queue and the table update
// in the back, which registers its result word together with the table change.
// Throughput: one word per cycle sustained while result words are taken (out_ch.ready).
// Reset (synchronous, rst high): table empty, queue empty, policy arrival order,
// quantum 10. Table contents are not cleared; only the fill count is.
module task_dispatch_scheduler_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst,
  tds_in_if.sink    in_ch,
  tds_out_if.source out_ch,
  tds_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  tds_pkg::policy_t              policy;
  logic [tds_pkg::TIME_W-1:0]    quantum;
  logic                          f_valid;
  tds_pkg::cmd_t                 f_cmd;
  logic                          f_ready;
  logic                          q_valid;
  tds_pkg::cmd_t                 q_cmd;
  logic                          q_ready;
  logic [CNT_W-1:0]              count;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= tds_pkg::POL_ARRIVAL;
      quantum <= tds_pkg::QUANTUM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tds_pkg::REG_POLICY:  policy  <= tds_pkg::policy_t'(cfg.data[1:0]);
        tds_pkg::REG_QUANTUM: quantum <= cfg.data;
        default: ;
      endcase
    end
  end

  tds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  tds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  tds_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .quantum   (quantum),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_ch    (out_ch),
    .count     (count)
  );

`ifndef SYNTH
  // Table never holds more tasks than it has cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("task count exceeds table size");

  // An unfinished slice always leaves time on the task
  a_requeue_left: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == tds_pkg::STAT_SLICE) && !out_ch.finished)
    |-> (out_ch.remaining != '0))
    else $error("task requeued with no time left");

  // Words other than a slice carry zero run fields
  a_nonslice_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != tds_pkg::STAT_SLICE))
    |-> ((out_ch.run_id == '0) && (out_ch.ran == '0) && (out_ch.remaining == '0)
         && !out_ch.finished))
    else $error("run fields set on a non-slice result");

  // A clear result leaves the table empty
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_ch.valid) && (out_ch.status == tds_pkg::STAT_CLEAR)) |-> (count == '0))
    else $error("table not empty after clear");
`endif

endmodule
